// ===== rtl/pbc_pkg.sv =====
// Shared constants, codes and constant functions of the pixel blend combiner.
package pbc_pkg;

  localparam int DEF_PIXEL_WIDTH = 24;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int Q30_BITS        = 30;

  typedef enum logic [3:0] {
    MODE_AVG    = 4'd0,
    MODE_ADD    = 4'd1,
    MODE_MUL    = 4'd2,
    MODE_SUB    = 4'd3,
    MODE_DIV    = 4'd4,
    MODE_MIN    = 4'd5,
    MODE_MAX    = 4'd6,
    MODE_POW    = 4'd7,
    MODE_SCREEN = 4'd8
  } blend_mode_t;

  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_STRENGTH = 2'd1,
    CFG_PRESENT  = 2'd2
  } cfg_index_t;

  function automatic logic [63:0] pbc_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] bt;
    int k;
    rem = v;
    r   = '0;
    bt  = 64'd1 << 62;
    for (k = 0; k < 32; k++) begin
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // 2^(2^-idx) in Q30, by repeated square roots from 2
  function automatic logic [30:0] pbc_pow_factor(input int idx);
    logic [63:0] c;
    int j;
    c = pbc_isqrt(64'd2 << 60);
    for (j = 1; j < idx; j++) begin
      c = pbc_isqrt(c << Q30_BITS);
    end
    return c[30:0];
  endfunction

endpackage

// ===== rtl/pixel_blend_combiner.sv =====
// Pixel blend combiner: pipelined two-sample blend under a configured mode and strength.
//
// Takes one pixel pair per clock and returns one blended pixel per clock, in order, while the
// output is not stalled. Every pixel runs the full pipeline whatever the mode: the depth is
// set by the longer of the power path, a 30-stage log2 squaring chain followed by a 30-stage
// exp2 product chain, and the divider, one quotient bit per stage. The whole pipeline holds
// while an output beat waits to be taken. Configuration writes must be made while no pixel
// is in flight.
module pixel_blend_combiner
  import pbc_pkg::*;
#(
  parameter int PIXEL_WIDTH = DEF_PIXEL_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // pixel_a, pixel_b
  input  logic [((2*PIXEL_WIDTH+7)/8)*8-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // pixel_out
  output logic [((PIXEL_WIDTH+7)/8)*8-1:0]      m_tdata,
  // clipped
  output logic                                  m_tuser,
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_index,
  input  logic [PIXEL_WIDTH-1:0]                cfg_data
);

  localparam int W    = PIXEL_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int TDO  = ((W + 7) / 8) * 8;
  localparam int OW   = (W > F + 2) ? W : F + 2;
  localparam int BW   = OW + 1;
  localparam int PW1  = W + BW;
  localparam int ME   = ((PW1 - F > OW) ? PW1 - F : OW) + 1;
  localparam int RS   = ME + 1;
  localparam int PAM  = W + ME;
  localparam int PSW  = BW + ME + 1;
  localparam int RW   = PSW + 2;
  localparam int NQ   = W + F;
  localparam int LGW  = 37;
  localparam int PLW  = ME + 19;
  localparam int PFW  = ME + LGW + 1;
  localparam int NW   = PFW - Q30_BITS;

  localparam int S_PROD     = 1;
  localparam int S_MIX      = 2;
  localparam int S_SET      = 3;
  localparam int S_R2       = 4;
  localparam int LOG_FIRST  = 3;
  localparam int LOG_LAST   = LOG_FIRST + Q30_BITS - 1;
  localparam int DIV_FIRST  = 4;
  localparam int DIV_LAST   = DIV_FIRST + NQ - 1;
  localparam int S_LG       = LOG_LAST + 1;
  localparam int S_P        = S_LG + 1;
  localparam int S_EXPSET   = S_P + 1;
  localparam int EXP_FIRST  = S_EXPSET + 1;
  localparam int S_POW      = EXP_FIRST + Q30_BITS;
  localparam int FIN        = (S_POW + 1 > DIV_LAST + 1) ? S_POW + 1 : DIV_LAST + 1;
  localparam int DEPTH      = FIN + 1;

  localparam logic signed [W-1:0]   ONE_W   = W'(1) << F;
  localparam logic signed [BW-1:0]  ONE_B   = BW'(1) << F;
  localparam logic signed [ME-1:0]  ONE_M   = ME'(1) << F;
  localparam logic signed [ME:0]    ONE_M1  = (ME + 1)'(1) << F;
  localparam logic signed [RW-1:0]  ONE_R   = RW'(1) << F;
  localparam logic signed [PW1-1:0] BIAS1   = (PW1'(1) << F) - PW1'(1);
  localparam logic signed [PAM-1:0] BIAS_AM = (PAM'(1) << F) - PAM'(1);
  localparam logic signed [PSW-1:0] BIAS_SC = (PSW'(1) << F) - PSW'(1);
  localparam logic signed [PFW-1:0] BIAS_P  = (PFW'(1) << F) - PFW'(1);
  localparam logic signed [RW-1:0]  VMAX_R  = (RW'(1) << (W - 1)) - RW'(1);
  localparam logic signed [RW-1:0]  VMIN_R  = -(RW'(1) << (W - 1));
  localparam logic signed [NW-1:0]  N_SAT   = NW'(W - 1 - F);
  localparam logic signed [NW-1:0]  N_ZERO  = NW'(-2 - F);
  localparam logic signed [NW-1:0]  N_SHB   = NW'(Q30_BITS - F);

  typedef struct packed {
    logic signed [W-1:0]   a;
    logic signed [W-1:0]   b;
    logic signed [PW1-1:0] psbo;
    logic signed [PW1-1:0] psba;
    logic signed [PW1-1:0] psb;
    logic signed [ME-1:0]  m;
    logic signed [ME-1:0]  tsb;
    logic signed [RS-1:0]  rsim;
    logic signed [PAM-1:0] pam;
    logic signed [PSW-1:0] pscr;
    logic signed [RW-1:0]  rmul;
    logic signed [RW-1:0]  rscr;
    logic [4:0]            msb;
    logic [30:0]           lx;
    logic [29:0]           frac;
    logic [NQ-1:0]         dvd;
    logic [ME-1:0]         dvs;
    logic [ME-1:0]         rem;
    logic                  dneg;
    logic                  dzero;
    logic signed [PLW-1:0] plo;
    logic signed [PLW-1:0] phi;
    logic signed [NW-1:0]  pn;
    logic [29:0]           pf;
    logic                  psat;
    logic                  pzero;
    logic [4:0]            sh;
    logic [30:0]           y;
    logic signed [RW-1:0]  rpow;
    logic                  pclip;
    logic signed [RW-1:0]  r;
    logic                  clip;
    logic [W-1:0]          pout;
    logic                  oclip;
  } item_t;

  logic [3:0]          blend_mode;
  logic signed [W-1:0] blend_strength;
  logic                second_present;

  logic       ce;
  logic       s_acc;
  logic       m_acc;
  logic [DEPTH:0] v;
  item_t      in_item;
  item_t      nx [0:DEPTH];
  item_t      st [0:DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode     <= MODE_ADD;
      blend_strength <= ONE_W;
      second_present <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:     blend_mode     <= cfg_data[3:0];
        CFG_STRENGTH: blend_strength <= cfg_data;
        CFG_PRESENT:  second_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ce       = !v[DEPTH] || m_tready;
  assign s_tready = ce;
  assign s_acc    = s_tvalid && ce;
  assign m_acc    = v[DEPTH] && m_tready;
  assign m_tvalid = v[DEPTH];
  assign m_tdata  = TDO'(st[DEPTH].pout);
  assign m_tuser  = st[DEPTH].oclip;

  always_comb begin
    in_item   = '0;
    in_item.a = s_tdata[W-1:0];
    in_item.b = s_tdata[2*W-1:W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[DEPTH-1:0], s_tvalid};
    end
  end

  for (genvar K = 0; K <= DEPTH; K++) begin : g_stage
    localparam int EI = K - EXP_FIRST + 1;
    localparam int FB = (EI >= 1 && EI <= Q30_BITS) ? Q30_BITS - EI : 0;
    localparam logic [30:0] CF = pbc_pow_factor(EI);
    item_t src;

    if (K == 0) begin : g_first
      assign src = in_item;
    end else begin : g_next
      assign src = st[K-1];
    end

    always_comb begin
      logic signed [BW-1:0]  bo;
      logic signed [BW-1:0]  ba;
      logic signed [BW-1:0]  oma;
      logic signed [ME:0]    omt;
      logic signed [PW1-1:0] t1;
      logic signed [PW1-1:0] t2;
      logic signed [PW1-1:0] t3;
      logic signed [PAM-1:0] tam;
      logic signed [PSW-1:0] tsc;
      logic [61:0]           nrm;
      logic [61:0]           sq;
      logic [61:0]           ex;
      logic [W-1:0]          aabs;
      logic [ME:0]           trial;
      logic [6:0]            msbmf;
      logic signed [LGW-1:0] lg;
      logic signed [PFW-1:0] pfull;
      logic signed [RW-1:0]  q;
      logic signed [RW-1:0]  r;
      logic                  clip;
      nx[K] = src;

      if (K == S_PROD) begin
        bo = BW'(src.b) - ONE_B;
        ba = BW'(src.b) - BW'(src.a);
        nx[K].psbo = PW1'(blend_strength) * PW1'(bo);
        nx[K].psba = PW1'(blend_strength) * PW1'(ba);
        nx[K].psb  = PW1'(blend_strength) * PW1'(src.b);
      end

      if (K == S_MIX) begin
        t1 = src.psbo;
        t2 = src.psba;
        t3 = src.psb;
        if (t1[PW1-1]) t1 = t1 + BIAS1;
        if (t2[PW1-1]) t2 = t2 + BIAS1;
        if (t3[PW1-1]) t3 = t3 + BIAS1;
        t1 = t1 >>> F;
        t2 = t2 >>> F;
        t3 = t3 >>> F;
        nx[K].m   = ME'(t1) + ONE_M;
        nx[K].tsb = ME'(t3);
        case (blend_mode)
          MODE_AVG: nx[K].rsim = RS'(src.a) + RS'(t2);
          MODE_ADD: nx[K].rsim = RS'(src.a) + RS'(t3);
          MODE_SUB: nx[K].rsim = RS'(src.a) - RS'(t3);
          MODE_MIN: nx[K].rsim = (RS'(src.a) < RS'(ME'(t1) + ONE_M)) ?
                                 RS'(src.a) : RS'(ME'(t1) + ONE_M);
          MODE_MAX: nx[K].rsim = (RS'(src.a) > RS'(t3)) ? RS'(src.a) : RS'(t3);
          default:  nx[K].rsim = RS'(src.a);
        endcase
        nx[K].msb = '0;
        for (int j = 0; j < W - 1; j++) begin
          if (src.a[j]) nx[K].msb = 5'(j);
        end
        nrm = 62'(src.a[W-2:0]) << (Q30_BITS - int'(nx[K].msb));
        nx[K].lx   = nrm[30:0];
        nx[K].frac = '0;
      end

      if (K == S_SET) begin
        oma = ONE_B - BW'(src.a);
        omt = ONE_M1 - (ME + 1)'(src.tsb);
        nx[K].pam  = PAM'(src.a) * PAM'(src.m);
        nx[K].pscr = PSW'(oma) * PSW'(omt);
        aabs = src.a[W-1] ? W'(-src.a) : W'(src.a);
        nx[K].dvd   = NQ'(aabs) << F;
        nx[K].dvs   = src.m[ME-1] ? ME'(-src.m) : ME'(src.m);
        nx[K].rem   = '0;
        nx[K].dneg  = src.a[W-1] ^ src.m[ME-1];
        nx[K].dzero = (src.m == '0);
      end

      if (K == S_R2) begin
        tam = src.pam;
        tsc = src.pscr;
        if (tam[PAM-1]) tam = tam + BIAS_AM;
        if (tsc[PSW-1]) tsc = tsc + BIAS_SC;
        tam = tam >>> F;
        tsc = tsc >>> F;
        nx[K].rmul = RW'(tam);
        nx[K].rscr = ONE_R - RW'(tsc);
      end

      if (K >= LOG_FIRST && K <= LOG_LAST) begin
        sq = 62'(src.lx) * 62'(src.lx);
        if (sq[61]) begin
          nx[K].lx   = sq[61:31];
          nx[K].frac = {src.frac[28:0], 1'b1};
        end else begin
          nx[K].lx   = sq[60:30];
          nx[K].frac = {src.frac[28:0], 1'b0};
        end
      end

      if (K >= DIV_FIRST && K <= DIV_LAST) begin
        trial = {src.rem, src.dvd[NQ-1]};
        if (trial >= {1'b0, src.dvs}) begin
          nx[K].rem = ME'(trial - {1'b0, src.dvs});
          nx[K].dvd = {src.dvd[NQ-2:0], 1'b1};
        end else begin
          nx[K].rem = trial[ME-1:0];
          nx[K].dvd = {src.dvd[NQ-2:0], 1'b0};
        end
      end

      if (K == S_LG) begin
        msbmf = 7'(src.msb) - 7'(F);
        lg = {msbmf, src.frac};
        nx[K].plo = PLW'(src.m) * PLW'($signed({1'b0, lg[17:0]}));
        nx[K].phi = PLW'(src.m) * PLW'($signed(lg[LGW-1:18]));
      end

      if (K == S_P) begin
        pfull = (PFW'(src.phi) <<< 18) + PFW'(src.plo);
        if (pfull[PFW-1]) pfull = pfull + BIAS_P;
        pfull = pfull >>> F;
        nx[K].pn = NW'(pfull >>> Q30_BITS);
        nx[K].pf = pfull[29:0];
      end

      if (K == S_EXPSET) begin
        nx[K].psat  = (src.pn >= N_SAT);
        nx[K].pzero = (src.pn <= N_ZERO);
        nx[K].sh    = 5'(N_SHB - src.pn);
        nx[K].y     = 31'd1 << Q30_BITS;
      end

      if (K >= EXP_FIRST && K < S_POW) begin
        ex = 62'(src.y) * 62'(CF);
        if (src.pf[FB]) nx[K].y = ex[60:30];
      end

      if (K == S_POW) begin
        nx[K].rpow  = src.psat ? VMAX_R :
                      (src.pzero ? RW'(0) : RW'(src.y >> src.sh));
        nx[K].pclip = src.psat;
      end

      if (K == FIN) begin
        q    = RW'($signed({1'b0, src.dvd}));
        r    = RW'(src.a);
        clip = 1'b0;
        if (second_present) begin
          case (blend_mode)
            MODE_AVG, MODE_ADD, MODE_SUB, MODE_MIN, MODE_MAX: r = RW'(src.rsim);
            MODE_MUL:    r = src.rmul;
            MODE_SCREEN: r = src.rscr;
            MODE_DIV: begin
              if (src.dzero) begin
                clip = 1'b1;
                r = (src.a > 0) ? VMAX_R : ((src.a < 0) ? VMIN_R : RW'(0));
              end else begin
                r = src.dneg ? -q : q;
              end
            end
            MODE_POW: begin
              if (src.a <= 0) begin
                clip = 1'b1;
                r = '0;
              end else begin
                r    = src.rpow;
                clip = src.pclip;
              end
            end
            default: clip = 1'b1;
          endcase
        end
        nx[K].r    = r;
        nx[K].clip = clip;
      end

      if (K == DEPTH) begin
        if (src.r > VMAX_R) begin
          nx[K].pout  = W'(VMAX_R);
          nx[K].oclip = 1'b1;
        end else if (src.r < VMIN_R) begin
          nx[K].pout  = W'(VMIN_R);
          nx[K].oclip = 1'b1;
        end else begin
          nx[K].pout  = src.r[W-1:0];
          nx[K].oclip = src.clip;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st[K] <= nx[K];
      end
    end
  end

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(v) == $past($countones(v)) + int'($past(s_acc)) - int'($past(m_acc)))
    else $error("pipeline beat count mismatch");

  assert property (@(posedge clk) disable iff (rst)
    v[DIV_LAST] && !st[DIV_LAST].dzero |-> st[DIV_LAST].rem < st[DIV_LAST].dvs)
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    v[LOG_LAST] && st[LOG_LAST].a > 0 |-> st[LOG_LAST].lx[30])
    else $error("log mantissa lost normalization");

endmodule
